// File: rtl/integer_matrix_multiply_top_defines.svh
// Assertion macros for the integer matrix multiply block.
// Used by integer_matrix_multiply_top.sv; expects clk and rst_n in scope.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IMM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition never holds
`define IMM_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/imm_pkg.sv
// Shared types, constants and helpers of the integer matrix multiply block.
// No dependencies; used by imm_mac and integer_matrix_multiply_top.
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int IDX_FLD_W  = 3;
    localparam int VAL_FLD_W  = 32;
    localparam int TDATA_W    = 40;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_START  = 2'd2
    } func_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROWS_A  = 2'd0,
        REG_INNER_A = 2'd1,
        REG_ROWS_B  = 2'd2,
        REG_COLS_B  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last_k;
    } mac_ctl_t;

    function automatic logic [CFG_W-1:0] dim_clamp(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] max_dim);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (v > max_dim)
        begin
            r = max_dim;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/imm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/imm_mac.sv
// Multiply-accumulate pipeline: aligns control with RAM read data, registers
// the product, then adds into the accumulator. Depends on imm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imm_mac #(
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire imm_pkg::mac_ctl_t     ctl_in,
    input  wire logic [DATA_WIDTH-1:0] a_data,
    input  wire logic [DATA_WIDTH-1:0] b_data,
    output logic                       busy,
    output logic                       done,
    output logic      [DATA_WIDTH-1:0] sum
);

    imm_pkg::mac_ctl_t     s1_reg;
    imm_pkg::mac_ctl_t     s2_reg;
    logic [DATA_WIDTH-1:0] mul_reg;
    logic [DATA_WIDTH-1:0] mul_next;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] acc_next;

    always_comb
    begin
        mul_next = a_data * b_data;
        acc_next = (s2_reg.first ? '0 : acc_reg) + mul_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            s1_reg <= ctl_in;
            s2_reg <= s1_reg;
            if (s2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
    end

    assign busy = s1_reg.valid || s2_reg.valid;
    assign done = s2_reg.valid && s2_reg.last_k;
    assign sum  = acc_next;

endmodule

`default_nettype wire

// File: rtl/integer_matrix_multiply_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: row_in, col_in, elem_value
// m_*       out  m_tvalid/m_tready  tuser: dims_mismatch; tlast: last;
//                                   tdata: row_out, col_out, product_value
// cfg_*     in   cfg_we             cfg_addr: register index; cfg_wdata: value
//
// Load beat: written straight into the A or B store.
// Start beat: a dimension check, then for each product element one store read
// per inner step, the product register and the accumulate.
// Reset clears control only; the stores need no clearing pass.
// A stalled result holds the start of the next element; loads are accepted only while idle.
// Depends on imm_pkg, imm_ram, imm_mac and integer_matrix_multiply_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_matrix_multiply_top_defines.svh"

module integer_matrix_multiply_top #(
    parameter int MAX_DIM    = imm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = imm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [imm_pkg::TDATA_W-1:0]        s_tdata,   // row_in, col_in, elem_value, pad
    input  wire logic [1:0]                         s_tuser,   // func
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [imm_pkg::TDATA_W-1:0]        m_tdata,   // row_out, col_out, product_value, pad
    output logic                                    m_tlast,
    output logic                                    m_tuser,   // dims_mismatch
    input  wire logic                               cfg_we,
    input  wire logic [imm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [imm_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW     = imm_pkg::CFG_W;
    localparam int FW     = imm_pkg::IDX_FLD_W;
    localparam int VW     = imm_pkg::VAL_FLD_W;
    localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(MAX_DIM);
    localparam logic [CW-1:0]     DIM_C = CW'(MAX_DIM);

    imm_pkg::state_t       state_reg;
    imm_pkg::state_t       state_next;
    logic [IDX_W-1:0]      row_reg, row_next;
    logic [IDX_W-1:0]      col_reg, col_next;
    logic [IDX_W-1:0]      k_reg, k_next;

    logic [CW-1:0]         rows_a_reg, inner_a_reg, rows_b_reg, cols_b_reg;
    logic [CW-1:0]         dim_m, dim_n, dim_p, dim_q;

    logic                  out_valid_reg;
    logic [FW-1:0]         out_row_reg;
    logic [FW-1:0]         out_col_reg;
    logic [DATA_WIDTH-1:0] out_val_reg;
    logic                  out_last_reg;
    logic                  out_mism_reg;

    logic                  in_fire;
    logic                  out_free;
    imm_pkg::func_t        func;
    logic [FW-1:0]         row_in, col_in;
    logic [VW-1:0]         elem_value;
    logic                  load_ok;
    logic                  we_a, we_b;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr_a, raddr_b;
    logic [DATA_WIDTH-1:0] rd_a, rd_b;

    logic                  row_end, col_end, k_end;
    logic                  issue;
    logic                  mism_load;
    imm_pkg::mac_ctl_t     mac_ctl;
    logic                  mac_busy;
    logic                  mac_done;
    logic [DATA_WIDTH-1:0] mac_sum;
    logic [VW-1:0]         product_value;

    // input beat fields
    assign func       = imm_pkg::func_t'(s_tuser);
    assign row_in     = s_tdata[FW-1:0];
    assign col_in     = s_tdata[2*FW-1:FW];
    assign elem_value = s_tdata[2*FW+VW-1:2*FW];

    assign dim_m = imm_pkg::dim_clamp(rows_a_reg, DIM_C);
    assign dim_n = imm_pkg::dim_clamp(inner_a_reg, DIM_C);
    assign dim_p = imm_pkg::dim_clamp(rows_b_reg, DIM_C);
    assign dim_q = imm_pkg::dim_clamp(cols_b_reg, DIM_C);

    assign row_end = (CW'(row_reg) == dim_m - CW'(1));
    assign col_end = (CW'(col_reg) == dim_q - CW'(1));
    assign k_end   = (CW'(k_reg) == dim_n - CW'(1));

    assign s_tready = (state_reg == imm_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // load decode
    assign load_ok = ({1'b0, row_in} < (FW+1)'(MAX_DIM)) && ({1'b0, col_in} < (FW+1)'(MAX_DIM));
    assign waddr   = ADDR_W'(row_in) * DIM_A + ADDR_W'(col_in);

    always_comb
    begin
        we_a = 1'b0;
        we_b = 1'b0;
        unique case (func)
            imm_pkg::FUNC_LOAD_A: we_a = in_fire && load_ok;
            imm_pkg::FUNC_LOAD_B: we_b = in_fire && load_ok;
            default: ;
        endcase
    end

    assign raddr_a = ADDR_W'(row_reg) * DIM_A + ADDR_W'(k_reg);
    assign raddr_b = ADDR_W'(k_reg) * DIM_A + ADDR_W'(col_reg);

    imm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (elem_value[DATA_WIDTH-1:0]),
        .re    (issue),
        .raddr (raddr_a),
        .rdata (rd_a)
    );

    imm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (elem_value[DATA_WIDTH-1:0]),
        .re    (issue),
        .raddr (raddr_b),
        .rdata (rd_b)
    );

    assign mac_ctl.valid  = issue;
    assign mac_ctl.first  = (k_reg == '0);
    assign mac_ctl.last_k = k_end;

    imm_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_in (mac_ctl),
        .a_data (rd_a),
        .b_data (rd_b),
        .busy   (mac_busy),
        .done   (mac_done),
        .sum    (mac_sum)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        mism_load  = 1'b0;
        unique case (state_reg)
            imm_pkg::ST_IDLE:
            begin
                if (in_fire && (func == imm_pkg::FUNC_START))
                begin
                    state_next = imm_pkg::ST_START;
                end
            end
            imm_pkg::ST_START:
            begin
                if (out_free)
                begin
                    if (dim_n != dim_p)
                    begin
                        mism_load  = 1'b1;
                        state_next = imm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        k_next     = '0;
                        state_next = imm_pkg::ST_ISSUE;
                    end
                end
            end
            imm_pkg::ST_ISSUE:
            begin
                issue = 1'b1;
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = imm_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            imm_pkg::ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    if (row_end && col_end)
                    begin
                        state_next = imm_pkg::ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        if (col_end)
                        begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                        state_next = imm_pkg::ST_ISSUE;
                    end
                end
            end
            default: state_next = imm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imm_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg  <= CW'(1);
            inner_a_reg <= CW'(1);
            rows_b_reg  <= CW'(1);
            cols_b_reg  <= CW'(1);
        end
        else if (cfg_we)
        begin
            unique case (imm_pkg::cfg_reg_t'(cfg_addr))
                imm_pkg::REG_ROWS_A:  rows_a_reg  <= cfg_wdata;
                imm_pkg::REG_INNER_A: inner_a_reg <= cfg_wdata;
                imm_pkg::REG_ROWS_B:  rows_b_reg  <= cfg_wdata;
                imm_pkg::REG_COLS_B:  cols_b_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (mac_done || mism_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_done)
        begin
            out_row_reg  <= FW'(row_reg);
            out_col_reg  <= FW'(col_reg);
            out_val_reg  <= mac_sum;
            out_last_reg <= row_end && col_end;
            out_mism_reg <= 1'b0;
        end
        else if (mism_load)
        begin
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_val_reg  <= '0;
            out_last_reg <= 1'b1;
            out_mism_reg <= 1'b1;
        end
    end

    assign product_value = VW'(signed'(out_val_reg));
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {{(imm_pkg::TDATA_W - 2*FW - VW){1'b0}}, product_value,
                            out_col_reg, out_row_reg};
    assign m_tlast       = out_last_reg;
    assign m_tuser       = out_mism_reg;

    `IMM_ASSERT_NEVER(a_no_overwrite, mac_done && out_valid_reg && !m_tready, "result overwritten while held")
    `IMM_ASSERT_NEVER(a_one_source, mac_done && mism_load, "two result sources in one cycle")
    `IMM_ASSERT_IMPLY(a_issue_empty, state_reg == imm_pkg::ST_ISSUE, !out_valid_reg, "output busy while issuing")
    `IMM_ASSERT_IMPLY(a_idle_quiet, s_tready, !mac_busy, "pipeline active while accepting beats")

endmodule

`default_nettype wire
